@@ src/blts_pkg.sv @@
// shared types and constants for the bilinear luminance texture sampler
package blts_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned AddrW = 16;
  localparam int unsigned LumaW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEX_WIDTH   = 3'd0,
    REG_TEX_HEIGHT  = 3'd1,
    REG_COORD_SCALE = 3'd2,
    REG_TILE_X      = 3'd3,
    REG_TILE_Y      = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  localparam logic [LumaW-1:0] EMPTY_LUMA = 16'd32768;

  // item handed from front to back
  typedef struct packed {
    logic             is_sample;
    logic             empty;
    logic [AddrW-1:0] waddr;
    logic [LumaW-1:0] wdata;
    logic [AddrW-1:0] a00;
    logic [AddrW-1:0] a10;
    logic [AddrW-1:0] a01;
    logic [AddrW-1:0] a11;
    logic [15:0]      tx;
    logic [15:0]      ty;
  } blts_cmd_t;

  // floor(v/3) for v < 3*2^16 (the result is LumaW bits) via reciprocal multiply and correction
  function automatic logic [LumaW-1:0] div3(input logic [17:0] v);
    logic [37:0] p;
    logic [17:0] q;
    logic [17:0] r;
    p = 38'(v) * 38'd87382;   // ceil(2^18/3)
    q = p[35:18];
    r = v - 18'(q * 18'd3);
    if (r[17]) q = q - 18'd1;
    else if (r >= 18'd3) q = q + 18'd1;
    return q[LumaW-1:0];
  endfunction

endpackage

@@ src/bilinear_luminance_texture_sampler_unit.sv @@
// top level of the bilinear luminance texture sampler
// structure: 3 front stages, a queue and 4 back stages
// throughput: one item per cycle while in_stall is low; reads of four neighbors
// go to four store copies
// writes give no result; a sample gives one luminance item
// reset (rst_n low, synchronous) clears handshake state and sets registers to
// width/height 0 and scale/repeat 1.0; the luma store is undefined until written
module bilinear_luminance_texture_sampler_unit #(
  parameter int unsigned MAX_WIDTH = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic [15:0]         in_texel_index,
  input  logic [15:0]         in_red,
  input  logic [15:0]         in_green,
  input  logic [15:0]         in_blue,
  input  logic signed [31:0]  in_coord_x,
  input  logic signed [31:0]  in_coord_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_luminance,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import blts_pkg::*;

  // configuration registers, always writable
  logic [8:0]  tex_width_r, tex_height_r;
  logic [23:0] coord_scale_r, tile_x_r, tile_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r   <= '0;
      tex_height_r  <= '0;
      coord_scale_r <= 24'h010000;
      tile_x_r      <= 24'h010000;
      tile_y_r      <= 24'h010000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:   tex_width_r   <= cfg_data[8:0];
        REG_TEX_HEIGHT:  tex_height_r  <= cfg_data[8:0];
        REG_COORD_SCALE: coord_scale_r <= cfg_data;
        REG_TILE_X:      tile_x_r      <= cfg_data;
        REG_TILE_Y:      tile_y_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end to queue
  blts_cmd_t f_cmd, q_cmd;
  logic      f_valid, f_ready, q_valid, q_ready;

  blts_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (in_opcode),
    .texel_index(in_texel_index),
    .red        (in_red),
    .green      (in_green),
    .blue       (in_blue),
    .coord_x    (in_coord_x),
    .coord_y    (in_coord_y),
    .tex_width  (tex_width_r),
    .tex_height (tex_height_r),
    .coord_scale(coord_scale_r),
    .tile_x     (tile_x_r),
    .tile_y     (tile_y_r),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  // decouples front stalls from back-end output stalls
  blts_queue #(.DEPTH(4)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data (f_cmd),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (q_cmd)
  );

  blts_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(q_valid),
    .cmd_ready(q_ready),
    .cmd      (q_cmd),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .luminance(out_luminance)
  );
endmodule

@@ src/blts_front.sv @@
// front end: luma computation, coordinate wrap and address generation
module blts_front #(
  parameter int unsigned MAX_WIDTH = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [15:0]          texel_index,
  input  logic [15:0]          red,
  input  logic [15:0]          green,
  input  logic [15:0]          blue,
  input  logic signed [31:0]   coord_x,
  input  logic signed [31:0]   coord_y,
  input  logic [8:0]           tex_width,
  input  logic [8:0]           tex_height,
  input  logic [23:0]          coord_scale,
  input  logic [23:0]          tile_x,
  input  logic [23:0]          tile_y,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output blts_pkg::blts_cmd_t  cmd
);
  import blts_pkg::*;

  // stage 1: coord * scale (low 48 bits of product suffice mod 2^48 frac)
  logic        s1_v_r, s2_v_r, s3_v_r;
  logic        s1_samp_r, s2_samp_r, s3_samp_r;
  logic        s1_empty_r, s2_empty_r, s3_empty_r;
  logic [15:0] s1_wa_r, s2_wa_r, s3_wa_r;
  logic [15:0] s1_wd_r, s2_wd_r, s3_wd_r;
  logic [47:0] s1_px_r, s1_py_r;
  logic [15:0] s2_u_r, s2_v2_r;
  logic [8:0]  s1_w_r, s1_h_r, s2_w_r, s2_h_r, s3_w_r;
  logic [23:0] s1_rx_r, s1_ry_r;
  logic [8:0]  s3_x0_r, s3_y0_r, s3_x1_r, s3_y1_r;
  logic [15:0] s3_tx_r, s3_ty_r;

  logic adv;
  // three-stage pipe; output held by a register that the queue drains
  assign adv = !s3_v_r || cmd_ready;
  assign in_stall = !adv;

  logic [23:0] sc, rx, ry;
  logic [8:0]  wsat, hsat;
  assign sc = (coord_scale == '0) ? 24'd1 : coord_scale;
  assign rx = (tile_x == '0) ? 24'd1 : tile_x;
  assign ry = (tile_y == '0) ? 24'd1 : tile_y;
  assign wsat = (32'(tex_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : tex_width;
  assign hsat = (32'(tex_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : tex_height;

  logic [47:0] mx, my;
  assign mx = {{16{coord_x[31]}}, coord_x} * 48'(sc);
  assign my = {{16{coord_y[31]}}, coord_y} * 48'(sc);

  // stage 2: times repeat mod 2^48, as two 24x24 products
  logic [47:0] lx, ly, hx, hy, qx, qy;
  assign lx = 48'(s1_px_r[23:0]) * 48'(s1_rx_r);
  assign hx = 48'(s1_px_r[47:24]) * 48'(s1_rx_r);
  assign ly = 48'(s1_py_r[23:0]) * 48'(s1_ry_r);
  assign hy = 48'(s1_py_r[47:24]) * 48'(s1_ry_r);
  assign qx = lx + {hx[23:0], 24'd0};
  assign qy = ly + {hy[23:0], 24'd0};

  logic [24:0] fx, fy;
  assign fx = 25'(s2_u_r) * 25'(s2_w_r - 9'd1);
  assign fy = 25'(s2_v2_r) * 25'(s2_h_r - 9'd1);
  logic [8:0] x0, y0, xn, yn;
  assign x0 = fx[24:16];
  assign y0 = fy[24:16];
  assign xn = ((x0 + 9'd1) < (s2_w_r - 9'd1)) ? x0 + 9'd1 : s2_w_r - 9'd1;
  assign yn = ((y0 + 9'd1) < (s2_h_r - 9'd1)) ? y0 + 9'd1 : s2_h_r - 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_samp_r  <= (op == OP_SAMPLE);
      s1_empty_r <= (tex_width == '0) || (tex_height == '0);
      s1_wa_r    <= texel_index;
      s1_wd_r    <= div3(18'(red) + 18'(green) + 18'(blue));
      s1_px_r    <= mx;
      s1_py_r    <= my;
      s1_rx_r    <= rx;
      s1_ry_r    <= ry;
      s1_w_r     <= wsat;
      s1_h_r     <= hsat;

      s2_samp_r  <= s1_samp_r;
      s2_empty_r <= s1_empty_r;
      s2_wa_r    <= s1_wa_r;
      s2_wd_r    <= s1_wd_r;
      s2_u_r     <= qx[47:32];
      s2_v2_r    <= qy[47:32];
      s2_w_r     <= s1_w_r;
      s2_h_r     <= s1_h_r;

      s3_samp_r  <= s2_samp_r;
      s3_empty_r <= s2_empty_r;
      s3_wa_r    <= s2_wa_r;
      s3_wd_r    <= s2_wd_r;
      s3_x0_r    <= x0;
      s3_y0_r    <= y0;
      s3_x1_r    <= xn;
      s3_y1_r    <= yn;
      s3_tx_r    <= fx[15:0];
      s3_ty_r    <= fy[15:0];
      s3_w_r     <= s2_w_r;
    end
  end

  // address = y*w + x mod 2^16
  logic [15:0] row0, row1;
  assign row0 = 16'(16'(s3_y0_r) * 16'(s3_w_r));
  assign row1 = 16'(16'(s3_y1_r) * 16'(s3_w_r));

  always_comb begin
    cmd.is_sample = s3_samp_r;
    cmd.empty     = s3_empty_r;
    cmd.waddr     = s3_wa_r;
    cmd.wdata     = s3_wd_r;
    cmd.a00       = row0 + 16'(s3_x0_r);
    cmd.a10       = row0 + 16'(s3_x1_r);
    cmd.a01       = row1 + 16'(s3_x0_r);
    cmd.a11       = row1 + 16'(s3_x1_r);
    cmd.tx        = s3_tx_r;
    cmd.ty        = s3_ty_r;
  end
  assign cmd_valid = s3_v_r;

  logic unused_w;
  assign unused_w = ^{qx[31:0], qy[31:0], hx[47:24], hy[47:24]};
endmodule

@@ src/blts_queue.sv @@
// short fifo between front end and back end
module blts_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  blts_pkg::blts_cmd_t  wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output blts_pkg::blts_cmd_t  rd_data
);
  import blts_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);

  blts_cmd_t         mem_r [DEPTH];
  logic [PtrW-1:0]   wp_r, rp_r;
  logic [PtrW:0]     cnt_r;
  logic              do_wr, do_rd;

  assign wr_ready = (cnt_r != (PtrW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == PtrW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == PtrW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end
endmodule

@@ src/blts_back.sv @@
// back end: luma store in four copies, bilinear blend, output register
module blts_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  blts_pkg::blts_cmd_t  cmd,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          luminance
);
  import blts_pkg::*;

  localparam int unsigned Depth = 1 << AddrW;

  // four replicated stores, one per neighbor, so all reads happen in the same cycle
  logic [LumaW-1:0] st0 [Depth];
  logic [LumaW-1:0] st1 [Depth];
  logic [LumaW-1:0] st2 [Depth];
  logic [LumaW-1:0] st3 [Depth];

  logic        b1_v_r, b2_v_r, b3_v_r, o_v_r;
  logic        b1_e_r, b2_e_r, b3_e_r;
  logic [15:0] b1_tx_r, b1_ty_r, b2_ty_r;
  logic [15:0] c00_r, c10_r, c01_r, c11_r;
  logic [32:0] r0_r, r1_r;
  logic [48:0] p0_r, p1_r;
  logic [15:0] o_d_r;
  logic        adv, take;

  assign adv = !o_v_r || !out_stall;
  assign cmd_ready = adv;
  assign take = cmd_valid && adv;

  always_ff @(posedge clk) begin
    if (take && !cmd.is_sample) begin
      st0[cmd.waddr] <= cmd.wdata;
      st1[cmd.waddr] <= cmd.wdata;
      st2[cmd.waddr] <= cmd.wdata;
      st3[cmd.waddr] <= cmd.wdata;
    end
    if (adv) begin
      c00_r <= st0[cmd.a00];
      c10_r <= st1[cmd.a10];
      c01_r <= st2[cmd.a01];
      c11_r <= st3[cmd.a11];
    end
  end

  logic [16:0] itx, ity;
  assign itx = 17'h10000 - 17'(b1_tx_r);
  assign ity = 17'h10000 - 17'(b2_ty_r);

  logic [49:0] acc;
  assign acc = 50'(p0_r) + 50'(p1_r) + 50'h80000000;

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_e_r  <= cmd.empty;
      b1_tx_r <= cmd.tx;
      b1_ty_r <= cmd.ty;
      r0_r    <= 33'(c00_r) * 33'(itx) + 33'(c10_r) * 33'(b1_tx_r);
      r1_r    <= 33'(c01_r) * 33'(itx) + 33'(c11_r) * 33'(b1_tx_r);
      b2_e_r  <= b1_e_r;
      b2_ty_r <= b1_ty_r;
      p0_r    <= 49'(r0_r) * 49'(ity);
      p1_r    <= 49'(r1_r) * 49'(b2_ty_r);
      b3_e_r  <= b2_e_r;
      if (b3_e_r) o_d_r <= EMPTY_LUMA;
      else if (acc[49:32] > 18'hFFFF) o_d_r <= 16'hFFFF;
      else o_d_r <= acc[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else if (adv) begin
      b1_v_r <= take && cmd.is_sample;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      o_v_r  <= b3_v_r;
    end
  end

  assign out_valid = o_v_r;
  assign luminance = o_d_r;
endmodule

@@ sim/blts_scoreboard.sv @@
// watches the sampler's channels, predicts each luminance item and compares
module blts_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_opcode,
  input  logic [15:0]        in_texel_index,
  input  logic [15:0]        in_red,
  input  logic [15:0]        in_green,
  input  logic [15:0]        in_blue,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_luminance,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import blts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WidthCap = 256;
  localparam int unsigned HeightCap = 256;

  logic [15:0] luma_mem [65536];
  logic [8:0]  width_q;
  logic [8:0]  height_q;
  logic [23:0] scale_q;
  logic [23:0] rep_x_q;
  logic [23:0] rep_y_q;
  logic [15:0] luma_due [$];
  int          fails = 0;
  int          due_cnt = 0;

  assign fail_count = fails;
  assign pending = due_cnt;

  // fraction of coord*scale*repeat, floored to 16 bits
  function automatic logic [15:0] wrapped_frac(input logic signed [31:0] c,
                                               input logic [23:0] s,
                                               input logic [23:0] r);
    logic [63:0] p;
    p = {{32{c[31]}}, c} * 64'(s == 0 ? 24'd1 : s) * 64'(r == 0 ? 24'd1 : r);
    return p[47:32];
  endfunction

  function automatic logic [15:0] luma_at(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] w);
    logic [31:0] a;
    a = y * w + x;
    return luma_mem[a[15:0]];
  endfunction

  function automatic logic [15:0] bilinear_luma(input logic signed [31:0] cx,
                                                input logic signed [31:0] cy);
    logic [31:0] w, h, fx, fy, x0, y0, x1, y1;
    logic [63:0] tx, ty, r0, r1, acc;
    if (width_q == 0 || height_q == 0) return EMPTY_LUMA;
    w = (width_q > WidthCap) ? WidthCap : 32'(width_q);
    h = (height_q > HeightCap) ? HeightCap : 32'(height_q);
    fx = 32'(wrapped_frac(cx, scale_q, rep_x_q)) * (w - 1);
    fy = 32'(wrapped_frac(cy, scale_q, rep_y_q)) * (h - 1);
    x0 = fx >> 16;
    y0 = fy >> 16;
    tx = 64'(fx[15:0]);
    ty = 64'(fy[15:0]);
    x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
    r0 = 64'(luma_at(x0, y0, w)) * (65536 - tx) + 64'(luma_at(x1, y0, w)) * tx;
    r1 = 64'(luma_at(x0, y1, w)) * (65536 - tx) + 64'(luma_at(x1, y1, w)) * tx;
    acc = (r0 * (65536 - ty) + r1 * ty + 64'h8000_0000) >> 32;
    return (acc > 64'hFFFF) ? 16'hFFFF : acc[15:0];
  endfunction

  always @(posedge clk) begin
    logic [17:0] sum;
    logic [15:0] want;
    if (!rst_n) begin
      width_q = '0;
      height_q = '0;
      scale_q = 24'd65536;
      rep_x_q = 24'd65536;
      rep_y_q = 24'd65536;
      luma_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_TEX_WIDTH:   width_q = cfg_data[8:0];
          REG_TEX_HEIGHT:  height_q = cfg_data[8:0];
          REG_COORD_SCALE: scale_q = cfg_data;
          REG_TILE_X:      rep_x_q = cfg_data;
          REG_TILE_Y:      rep_y_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (luma_due.size() == 0) begin
          $error("unexpected luminance item %0d", out_luminance);
          fails++;
        end else begin
          want = luma_due.pop_front();
          if (want !== out_luminance) begin
            $error("luminance: expected %0d, got %0d", want, out_luminance);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (op_t'(in_opcode) == OP_SAMPLE) begin
          luma_due.push_back(bilinear_luma(in_coord_x, in_coord_y));
        end else begin
          sum = 18'(in_red) + 18'(in_green) + 18'(in_blue);
          luma_mem[in_texel_index] = 16'(sum / 3);
        end
      end
    end
    due_cnt = luma_due.size();
  end

endmodule

@@ sim/bilinear_luminance_texture_sampler_unit_test.sv @@
// stimulus and verdict for the bilinear luminance texture sampler
module bilinear_luminance_texture_sampler_unit_test;
  import blts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic [15:0] in_texel_index = '0;
  logic [15:0] in_red = '0;
  logic [15:0] in_green = '0;
  logic [15:0] in_blue = '0;
  logic signed [31:0] in_coord_x = '0;
  logic signed [31:0] in_coord_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_luminance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  int fail_count;
  int pending;
  int burst_left = 0;
  // top asks the receiver for one long hold-off once the texture is filled
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  bilinear_luminance_texture_sampler_unit dut (.*);

  blts_scoreboard scoreboard (.*);

  // timeout guard
  initial begin
    #30ms;
    $display("tb: failure");
    $finish;
  end

  // receiver: stall pattern in segments, plus one long hold-off on request
  initial begin
    int mode;
    int len;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        @(negedge clk) out_stall <= 1'b1;
        repeat (300) @(negedge clk);  // pipeline fills, input must stall
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 60);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;                          // stretch without stalls
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // one item on the input channel; gaps come between bursts of random length
  task automatic send_item(input op_t op, input logic [15:0] idx,
                           input logic [15:0] r, input logic [15:0] g,
                           input logic [15:0] b, input logic [31:0] cx,
                           input logic [31:0] cy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_texel_index <= idx;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_coord_x <= cx;
    in_coord_y <= cy;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_texel(input logic [15:0] idx, input logic [15:0] r,
                             input logic [15:0] g, input logic [15:0] b);
    send_item(OP_WRITE, idx, r, g, b, $urandom, $urandom);
  endtask

  task automatic sample_at(input logic [31:0] cx, input logic [31:0] cy);
    send_item(OP_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              cx, cy);
  endtask

  // registers change only when the block has drained
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (15) @(negedge clk);  // writes in flight produce no item
  endtask

  task automatic set_regs(input logic [8:0] w, input logic [8:0] h,
                          input logic [23:0] s, input logic [23:0] rx,
                          input logic [23:0] ry);
    logic [23:0] vals [5];
    cfg_reg_t regs [5];
    vals = '{24'(w), 24'(h), s, rx, ry};
    regs = '{REG_TEX_WIDTH, REG_TEX_HEIGHT, REG_COORD_SCALE, REG_TILE_X, REG_TILE_Y};
    foreach (regs[i]) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
      2: return $urandom_range(0, 32'hFFFF);
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return {16'($urandom_range(0, 3)), 16'($urandom)};
    endcase
  endfunction

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly samples with random coordinates, some texel rewrites mixed in
  task automatic random_items(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) sample_at(rand_coord(), rand_coord());
      else write_texel(16'($urandom_range(0, 511)), rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  initial begin
    logic [8:0] w_pick;
    logic [8:0] h_pick;
    int ws;
    int h_top;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // empty texture right after reset
    sample_at(32'h0, 32'h0);
    sample_at(32'h8000_0000, 32'h7FFF_FFFF);

    // fill the first 512 texels; every geometry below stays within them
    for (int i = 0; i < 512; i++) begin
      write_texel(16'(i), rand_chan(), rand_chan(), rand_chan());
    end
    drain();

    // directed: channel extremes and coordinate corners on a full-width texture
    set_regs(9'd256, 9'd2, 24'd65536, 24'd65536, 24'd65536);
    write_texel(16'd0, 16'h0000, 16'h0000, 16'h0000);
    write_texel(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_texel(16'd256, 16'hFFFF, 16'h0000, 16'h0001);
    write_texel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'h0000_FFFF, 32'h0000_FFFF);
    sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    sample_at(32'h8000_0000, 32'h8000_0000);
    sample_at(32'hFFFF_FFFF, 32'h0000_8000);
    sample_at(32'h0000_0101, 32'hFFFF_0000);
    sample_at(32'h0000_8000, 32'hFFFF_FFFF);
    drain();

    // zero scale and repeats act as one lsb; receiver holds off meanwhile
    set_regs(9'd256, 9'd2, 24'd0, 24'd0, 24'd0);
    hold_req = 1'b1;
    random_items(200);
    drain();

    // single texel with maximal factors
    set_regs(9'd1, 9'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    random_items(150);
    drain();

    // oversized width, then oversized height, saturate
    set_regs(9'd511, 9'd2, 24'd65536, 24'($urandom), 24'($urandom));
    random_items(150);
    drain();
    set_regs(9'd2, 9'd511, 24'd65536, 24'($urandom), 24'($urandom));
    random_items(150);
    drain();

    // zero height and zero width give the empty value
    set_regs(9'($urandom_range(2, 20)), 9'd0, 24'($urandom), 24'($urandom),
             24'($urandom));
    random_items(60);
    drain();
    set_regs(9'd0, 9'd5, 24'($urandom), 24'($urandom), 24'($urandom));
    random_items(60);
    drain();

    // random geometries and factors, kept within the filled texels
    repeat (4) begin
      w_pick = 9'($urandom_range(1, 300));
      ws = (w_pick > 9'd256) ? 256 : int'(w_pick);
      h_top = (512 / ws > 300) ? 300 : 512 / ws;
      h_pick = 9'($urandom_range(1, h_top));
      set_regs(w_pick, h_pick,
               $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 24'h3_0000)),
               24'($urandom_range(0, 24'h4_0000)), 24'($urandom));
      random_items(150);
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
